// ===== rtl/core/phm_pkg.sv =====
`default_nettype none

package phm_pkg;

    localparam int unsigned SampleWidth = 16;
    localparam int unsigned LevelWidth  = 25;
    localparam int unsigned HoldWidth   = 16;
    localparam int unsigned WidenShift  = 9;
    localparam int unsigned CfgIdxWidth = 2;

    // Full scale (1.0) with 24 fractional bits.
    localparam logic [LevelWidth-1:0] LevelOne = 25'd16777216;

    localparam logic [HoldWidth-1:0]  HoldSamplesRst = 16'd11025;
    // About 0.5 / 11025 with 24 fractional bits.
    localparam logic [LevelWidth-1:0] FalloffStepRst = 25'd761;
    localparam logic                  RectifyRst     = 1'b1;

    typedef logic signed [SampleWidth-1:0] sample_t;
    typedef logic [LevelWidth-1:0]         level_t;
    typedef logic [HoldWidth-1:0]          hold_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_HOLD_SAMPLES = 2'd0,
        CFG_FALLOFF_STEP = 2'd1,
        CFG_RECTIFY      = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_CLEAR  = 1'b1
    } kind_t;

endpackage : phm_pkg

`default_nettype wire

// ===== rtl/core/peak_hold_meter_core.sv =====
`default_nettype none

// Channel   Handshake           Payload                         Direction
// -------   -----------------   -----------------------------   ---------
// input     s_valid / s_ready   s_kind, s_sample                in
// result    m_valid / m_ready   m_sample_out, m_peak_level      out
// config    cfg_wr_en           cfg_index, cfg_wr_data          in
//
// One beat in, one beat out. A beat passes through the input register and
// then lands in the result register; a new beat is taken every cycle
// unless the result register stalls. The loop through the peak compare,
// clamp and falloff subtract on peak_reg sets that rate.
// Synchronous active-low reset empties both stages, zeroes peak and hold,
// and loads the register defaults (hold 11025, falloff 761, rectify on).
// A stalled result register holds; the input register then holds too and
// s_ready drops, so no beat is lost or repeated.

module peak_hold_meter_core (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     s_valid,
    output      logic                     s_ready,
    input  wire logic                     s_kind,
    input  wire phm_pkg::sample_t         s_sample,

    output      logic                     m_valid,
    input  wire logic                     m_ready,
    output      phm_pkg::sample_t         m_sample_out,
    output      phm_pkg::level_t          m_peak_level,

    input  wire logic                     cfg_wr_en,
    input  wire logic [phm_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [phm_pkg::LevelWidth-1:0]  cfg_wr_data
);
    import phm_pkg::*;

    // Configuration registers.
    hold_t   hold_samples_reg;
    level_t  falloff_step_reg;
    logic    rectify_reg;

    // Input stage.
    logic    in_valid_reg;
    kind_t   in_kind_reg;
    sample_t in_sample_reg;

    // Meter state.
    level_t  peak_reg;
    level_t  peak_next;
    hold_t   hold_reg;
    hold_t   hold_next;

    // Result stage.
    logic    out_valid_reg;
    sample_t out_sample_reg;
    sample_t out_sample_next;
    level_t  out_peak_reg;

    logic                   advance;
    logic [SampleWidth-1:0] magnitude;
    level_t                 level;
    logic                   new_peak;
    level_t                 peak_hit;
    hold_t                  hold_hit;

    // Move the input beat on whenever the result slot is free or drains.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_sample_reg;
    assign m_peak_level = out_peak_reg;

    // Rectify, then widen Q1.15 to 24 fractional bits. A negative sample
    // without rectify maps to zero, which can never beat the peak.
    always_comb begin
        if (in_sample_reg[SampleWidth-1]) begin
            if (rectify_reg) begin
                magnitude = SampleWidth'(~in_sample_reg + 1'b1);
            end else begin
                magnitude = '0;
            end
        end else begin
            magnitude = in_sample_reg;
        end
        level = {magnitude, {WidenShift{1'b0}}};
    end

    // Peak capture with clamp at full scale, then hold countdown or decay; a clear beat zeroes all.
    always_comb begin
        new_peak = (level > peak_reg);
        if (new_peak) begin
            peak_hit = (level > LevelOne) ? LevelOne : level;
            hold_hit = hold_samples_reg;
        end else begin
            peak_hit = peak_reg;
            hold_hit = hold_reg;
        end

        if (in_kind_reg == KIND_CLEAR) begin
            peak_next       = '0;
            hold_next       = '0;
            out_sample_next = '0;
        end else begin
            out_sample_next = in_sample_reg;
            if (hold_hit != '0) begin
                hold_next = hold_hit - 1'b1;
                peak_next = peak_hit;
            end else begin
                hold_next = '0;
                peak_next = (falloff_step_reg >= peak_hit) ? '0
                                                           : peak_hit - falloff_step_reg;
            end
        end
    end

    // Configuration writes; an unknown index is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_samples_reg <= HoldSamplesRst;
            falloff_step_reg <= FalloffStepRst;
            rectify_reg      <= RectifyRst;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_HOLD_SAMPLES: hold_samples_reg <= cfg_wr_data[HoldWidth-1:0];
                CFG_FALLOFF_STEP: falloff_step_reg <= cfg_wr_data;
                CFG_RECTIFY:      rectify_reg      <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Control: stage valids and meter state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
            hold_reg      <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                peak_reg      <= peak_next;
                hold_reg      <= hold_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_kind_reg   <= kind_t'(s_kind);
            in_sample_reg <= s_sample;
        end
        if (advance) begin
            out_sample_reg <= out_sample_next;
            out_peak_reg   <= peak_next;
        end
    end

    // A clear beat leaves the meter at rest.
    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_kind_reg == KIND_CLEAR) |=> (peak_reg == '0 && hold_reg == '0))
        else $error("clear did not zero peak and hold");

    // The peak never passes full scale.
    a_peak_range: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg <= LevelOne)
        else $error("peak above full scale");

    // The result carries the state the beat left behind.
    a_result_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_valid && m_peak_level == peak_reg))
        else $error("result peak differs from stored peak");

    // A running hold counts down by one when no new peak arrives.
    a_hold_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_kind_reg == KIND_SAMPLE && hold_reg != '0 && !new_peak)
        |=> (hold_reg == $past(hold_reg) - 1'b1))
        else $error("hold counter did not step down");

    // An empty result register never blocks the input side.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with an empty result register");

endmodule : peak_hold_meter_core

`default_nettype wire

// ===== tb/tb_peak_hold_meter_core.sv =====
`default_nettype none

module tb_peak_hold_meter_core;
    import phm_pkg::*;

    localparam int HalfPeriod   = 6;
    localparam int ResetCycles  = 3;
    // Two pipeline stages; leave a little slack on top.
    localparam int SettleCycles = 4;
    localparam int CycleLimit   = 200000;
    localparam int DrainLimit   = 2000;
    localparam int ReportLimit  = 10;

    // Index 3 maps to no register; a write there must change nothing.
    localparam logic [CfgIdxWidth-1:0] CfgIdxSpare = 2'd3;
    localparam level_t  DataAllOnes = '1;
    localparam sample_t SampleMax   = 16'sh7FFF;
    localparam sample_t SampleMin   = 16'sh8000;

    typedef struct packed {
        sample_t sample_out;
        level_t  peak_level;
    } reading_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_valid     = 1'b0;
    logic                   s_kind      = KIND_SAMPLE;
    sample_t                s_sample    = '0;
    logic                   m_ready     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CfgIdxWidth-1:0] cfg_index   = CFG_HOLD_SAMPLES;
    level_t                 cfg_wr_data = '0;
    wire logic              s_ready;
    wire logic              m_valid;
    sample_t                m_sample_out;
    level_t                 m_peak_level;

    // Meter state and register copies kept by the testbench.
    hold_t  meter_hold_cfg = HoldSamplesRst;
    level_t meter_falloff  = FalloffStepRst;
    logic   meter_rectify  = RectifyRst;
    level_t meter_peak     = '0;
    hold_t  meter_hold_left = '0;

    reading_t pending_readings[$];
    int       mismatches   = 0;
    int       cycle_count  = 0;
    int       stall_left   = 0;
    bit       traffic_gaps = 1'b1;

    peak_hold_meter_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_peak_level (m_peak_level),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #HalfPeriod aclk = 1'b1;
        #HalfPeriod aclk = 1'b0;
    end

    // Advance the meter by one beat and return the reading it should emit.
    function automatic reading_t meter_step(kind_t kind, sample_t smp);
        int       lvl;
        reading_t r;
        if (kind == KIND_CLEAR) begin
            meter_peak      = '0;
            meter_hold_left = '0;
            r.sample_out    = '0;
            r.peak_level    = '0;
            return r;
        end
        lvl = int'(smp);
        if (meter_rectify && lvl < 0) begin
            lvl = -lvl;
        end
        // Q1.15 -> 24 fractional bits.
        lvl = lvl <<< WidenShift;
        if (lvl > 0 && lvl > int'(meter_peak)) begin
            meter_hold_left = meter_hold_cfg;
            meter_peak = (lvl > int'(LevelOne)) ? LevelOne : level_t'(lvl);
        end
        // Hold counts down first; decay starts only once it is spent.
        if (meter_hold_left != '0) begin
            meter_hold_left = meter_hold_left - 1'b1;
        end else if (meter_peak != '0) begin
            meter_peak = (meter_falloff >= meter_peak) ? '0 : meter_peak - meter_falloff;
        end
        r.sample_out = smp;
        r.peak_level = meter_peak;
        return r;
    endfunction

    function automatic void note_mismatch(string what, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (mismatches < ReportLimit) begin
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want, got);
        end
        mismatches++;
    endfunction

    // Signed sample with magnitude up to span; full 16-bit range past 32767.
    function automatic sample_t random_sample(int unsigned span);
        int v;
        if (span > 32767) begin
            return sample_t'($urandom);
        end
        v = $urandom_range(0, span);
        return sample_t'($urandom_range(0, 1) ? -v : v);
    endfunction

    // Drive one beat, hold it until taken, then log the expected reading.
    task automatic send_item(kind_t kind, sample_t smp);
        if (traffic_gaps && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_kind   <= kind;
        s_sample <= smp;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_readings.push_back(meter_step(kind, smp));
    endtask

    // Drop valid and hold off until every pending reading has come back.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, level_t data);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            CFG_HOLD_SAMPLES: meter_hold_cfg = data[HoldWidth-1:0];
            CFG_FALLOFF_STEP: meter_falloff  = data;
            CFG_RECTIFY:      meter_rectify  = data[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_meter(level_t hold_data, level_t falloff_data, level_t rectify_data);
        write_reg(CFG_HOLD_SAMPLES, hold_data);
        write_reg(CFG_FALLOFF_STEP, falloff_data);
        write_reg(CFG_RECTIFY, rectify_data);
    endtask

    // One loud beat, then a mostly quiet tail so the hold runs out and decay shows.
    task automatic send_burst(int unsigned quiet_len);
        send_item(KIND_SAMPLE, random_sample(32768));
        repeat (quiet_len) begin
            case ($urandom_range(0, 15))
                0:       send_item(KIND_CLEAR, random_sample(32768));
                1, 2:    send_item(KIND_SAMPLE, '0);
                3:       send_item(KIND_SAMPLE, random_sample(32768));
                default: send_item(KIND_SAMPLE, random_sample($urandom_range(0, 300)));
            endcase
        end
    endtask

    // Register defaults straight out of reset, full-scale negative included.
    task automatic test_reset_defaults();
        send_item(KIND_SAMPLE, 16'sh4000);
        send_item(KIND_SAMPLE, SampleMin);
        send_item(KIND_SAMPLE, SampleMax);
        send_item(KIND_SAMPLE, '0);
        send_item(KIND_CLEAR, SampleMax);
    endtask

    // Without rectify, negative samples never raise the peak; then with rectify on they do.
    task automatic test_signed_levels();
        set_meter(25'd2, 25'd1000, 25'd0);
        send_item(KIND_SAMPLE, 16'sd100);
        send_item(KIND_SAMPLE, SampleMin);
        send_item(KIND_SAMPLE, -16'sd1);
        send_item(KIND_SAMPLE, '0);
        write_reg(CFG_RECTIFY, 25'd1);
        send_item(KIND_SAMPLE, SampleMin);
        send_item(KIND_SAMPLE, -16'sd1);
    endtask

    // Zero hold decays a fresh peak at once; oversize falloff floors at zero.
    task automatic test_zero_hold_falloff();
        set_meter(25'd0, 25'd5000, 25'd1);
        send_item(KIND_SAMPLE, SampleMax);
        send_item(KIND_SAMPLE, 16'sd1);
        send_item(KIND_SAMPLE, '0);
        send_item(KIND_CLEAR, SampleMin);
        send_item(KIND_SAMPLE, 16'sd4);
        write_reg(CFG_FALLOFF_STEP, LevelOne);
        send_item(KIND_SAMPLE, SampleMin);
        write_reg(CFG_FALLOFF_STEP, 25'd0);
        send_item(KIND_SAMPLE, SampleMax);
        send_item(KIND_SAMPLE, '0);
    endtask

    // A write to the unused index must leave every register alone.
    task automatic test_spare_index();
        write_reg(CfgIdxSpare, DataAllOnes);
        send_item(KIND_SAMPLE, 16'sh1234);
        send_item(KIND_SAMPLE, '0);
    endtask

    // Clear in the middle of a hold drops both peak and counter.
    task automatic test_clear_in_hold();
        set_meter(25'd100, 25'd761, 25'd1);
        send_item(KIND_SAMPLE, SampleMax);
        send_item(KIND_CLEAR, 16'sh5555);
        send_item(KIND_SAMPLE, '0);
    endtask

    // Random traffic over a series of register settings, extremes first.
    task automatic test_random_phases();
        int     sent;
        int     qlen;
        level_t hold_data;
        level_t falloff_data;
        for (int phase = 0; phase < 10; phase++) begin
            // Random upper bits on the hold write check that only 16 bits land.
            hold_data = (level_t'($urandom) & ~level_t'(16'hFFFF))
                      | level_t'($urandom_range(0, 24));
            falloff_data = ($urandom_range(0, 3) == 0) ? level_t'($urandom_range(1, 2000))
                                                       : level_t'($urandom_range(20000, 3000000));
            case (phase)
                0: set_meter(25'd0, LevelOne, level_t'($urandom));
                1: set_meter(25'h00FFFF, 25'd0, level_t'($urandom));
                2: set_meter(level_t'($urandom_range(0, 8)), DataAllOnes, level_t'($urandom));
                default: set_meter(hold_data, falloff_data, level_t'($urandom));
            endcase
            // One phase runs without any idling on either side.
            traffic_gaps = (phase != 5);
            sent = 0;
            while (sent < 54) begin
                qlen = $urandom_range(0, 12);
                send_burst(qlen);
                sent += qlen + 1;
            end
        end
    endtask

    // Closing stretch: back-to-back beats, no idling anywhere.
    task automatic test_tail_stream();
        int sent;
        int qlen;
        traffic_gaps = 1'b0;
        set_meter(level_t'($urandom_range(0, 6)), level_t'($urandom_range(50000, 2000000)),
                  level_t'($urandom));
        sent = 0;
        while (sent < 50) begin
            qlen = $urandom_range(0, 10);
            send_burst(qlen);
            sent += qlen + 1;
        end
    endtask

    // Receiver side: random stall bursts while gaps are enabled.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (traffic_gaps && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each delivered beat with the oldest pending reading.
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_readings.size() == 0) begin
                note_mismatch("beat with nothing pending, peak_level", 'x, m_peak_level);
            end else begin
                want = pending_readings.pop_front();
                if (m_sample_out !== want.sample_out) begin
                    note_mismatch("sample_out", want.sample_out, m_sample_out);
                end
                if (m_peak_level !== want.peak_level) begin
                    note_mismatch("peak_level", want.peak_level, m_peak_level);
                end
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int waited;
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_signed_levels();
        test_zero_hold_falloff();
        test_spare_index();
        test_clear_in_hold();
        test_random_phases();
        test_tail_stream();

        // Drain: wait for the last readings, then let the pipeline empty.
        s_valid <= 1'b0;
        waited = 0;
        while (pending_readings.size() != 0 && waited < DrainLimit) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_readings.size() != 0) begin
            note_mismatch("readings never delivered", 0, pending_readings.size());
        end
        repeat (SettleCycles) @(posedge aclk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
